>>> sv/lzc_pkg.sv
// Shared types and constants for the LZ77 greedy compressor.
// Used by the controller, the datapath, the top level and the checker.
package lzc_pkg;

  localparam int unsigned OFF_W = 11;
  localparam int unsigned LEN_W = 5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       block_end;
  } lzc_in_t;

  typedef struct packed {
    logic             kind;
    logic [OFF_W-1:0] match_offset;
    logic [LEN_W-1:0] match_length;
    logic [7:0]       byte_value;
    logic             token_last;
  } lzc_out_t;

  localparam logic KIND_LITERAL = 1'b0;
  localparam logic KIND_MATCH   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_EMIT,
    ST_CONSUME
  } lzc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic search_start;
    logic search_run;
    logic emit;
    logic consume_step;
    logic clear_blk;
  } lzc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_token;
    logic blk_last;
    logic search_done;
    logic out_free;
    logic consume_last;
  } lzc_sts_t;

endpackage

>>> sv/lzc_ctrl.sv
// Sequencing controller of the LZ77 compressor: accept, search, emit, consume.
// Depends on lzc_pkg for the state, command and status types.
module lzc_ctrl
  import lzc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  lzc_sts_t sts_i,
  output logic     in_ready_o,
  output lzc_cmd_t cmd_o
);

  lzc_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.need_token ? ST_SEARCH : ST_IDLE;
      end
      ST_SEARCH: begin
        if (sts_i.search_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_CONSUME;
      end
      ST_CONSUME: begin
        if (sts_i.consume_last) state_d = ST_CHECK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.search_start = sts_i.need_token;
        cmd_o.clear_blk    = !sts_i.need_token && sts_i.blk_last;
      end
      ST_SEARCH: begin
        cmd_o.search_run = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      ST_CONSUME: begin
        cmd_o.consume_step = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> sv/lzc_dp.sv
// Datapath of the LZ77 compressor: history memory, lookahead, match window, token register.
// Depends on lzc_pkg; driven by lzc_ctrl commands.
module lzc_dp
  import lzc_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 1024,
  parameter int unsigned MAX_MATCH   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lzc_in_t  in_data_i,
  input  lzc_cmd_t cmd_i,
  output lzc_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lzc_out_t out_data_o
);

  localparam int unsigned LAD = MAX_MATCH + 1;
  localparam int unsigned AW  = $clog2(WINDOW_SIZE);
  localparam int unsigned FW  = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned LW  = $clog2(MAX_MATCH + 1);
  localparam int unsigned CW  = $clog2(MAX_MATCH + 2);
  localparam int unsigned LAI = $clog2(LAD);
  localparam int unsigned SW  = $clog2(WINDOW_SIZE + MAX_MATCH + 1);
  localparam logic [SW-1:0] M_S    = SW'(MAX_MATCH);
  localparam logic [FW-1:0] W_F    = FW'(WINDOW_SIZE);
  localparam logic [AW-1:0] W_LAST = AW'(WINDOW_SIZE - 1);
  localparam logic [CW-1:0] LAD_C  = CW'(LAD);

  // Storage
  logic [7:0]    hist_mem [WINDOW_SIZE];
  logic [7:0]    la_q     [LAD];
  logic [7:0]    win_q    [MAX_MATCH];
  logic [CW-1:0] cnt_q;
  logic          last_q;
  logic [FW-1:0] fill_q;
  logic [AW-1:0] head_q;
  logic [AW-1:0] rd_addr_q;
  logic [7:0]    rd_q;
  logic [SW-1:0] iss_q, wcnt_q;
  logic          elem_vld_q, sel_hist_q;
  logic [7:0]    la_elem_q;
  logic [LW-1:0] best_len_q;
  logic [FW-1:0] best_off_q;
  logic [CW-1:0] cons_q;
  logic          out_vld_q;
  lzc_out_t      out_q;

  logic [SW-1:0] fill_s, end_s, cand_pos;
  logic          issue, cand;
  logic [CW-1:0] limit;
  logic [LW-1:0] cur_len;
  logic [7:0]    elem;
  logic          is_match;
  logic [CW-1:0] take_n;

  assign fill_s   = SW'(fill_q);
  assign end_s    = fill_s + M_S;
  assign issue    = cmd_i.search_run && (iss_q < end_s);
  assign cand_pos = wcnt_q - M_S;
  assign cand     = cmd_i.search_run && (wcnt_q >= M_S) && (cand_pos < fill_s);
  assign limit    = cnt_q - CW'(1);
  assign elem     = sel_hist_q ? rd_q : la_elem_q;
  assign is_match = best_len_q >= LW'(2);
  assign take_n   = is_match ? CW'(best_len_q) + CW'(1) : CW'(1);

  // Count leading equal bytes of the window against the lookahead front
  always_comb begin
    logic run;
    run     = 1'b1;
    cur_len = '0;
    for (int k = 0; k < MAX_MATCH; k++) begin
      if (run && (CW'(k) < limit) && (win_q[k] == la_q[k])) begin
        cur_len = cur_len + LW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    sts_o.need_token   = (cnt_q == LAD_C) || (last_q && (cnt_q != '0));
    sts_o.blk_last     = last_q;
    sts_o.search_done  = (wcnt_q == end_s);
    sts_o.out_free     = !out_vld_q || out_ready_i;
    sts_o.consume_last = (cons_q == CW'(1));
  end

  // History memory: write on consume, registered read during search
  always_ff @(posedge clk_i) begin
    if (cmd_i.consume_step) begin
      hist_mem[head_q] <= la_q[0];
    end
    rd_q <= hist_mem[rd_addr_q];
  end

  // Lookahead, window and token payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      la_q[LAI'(cnt_q)] <= in_data_i.in_byte;
    end else if (cmd_i.consume_step) begin
      for (int i = 0; i < LAD - 1; i++) la_q[i] <= la_q[i+1];
    end
    if (issue) begin
      la_elem_q <= la_q[LAI'(iss_q - fill_s)];
    end
    if (elem_vld_q) begin
      for (int j = 0; j < MAX_MATCH - 1; j++) win_q[j] <= win_q[j+1];
      win_q[MAX_MATCH-1] <= elem;
    end
    if (cmd_i.emit) begin
      out_q.kind         <= is_match ? KIND_MATCH : KIND_LITERAL;
      out_q.match_offset <= is_match ? OFF_W'(best_off_q) : '0;
      out_q.match_length <= is_match ? LEN_W'(best_len_q) : '0;
      out_q.byte_value   <= is_match ? la_q[LAI'(best_len_q)] : la_q[0];
      out_q.token_last   <= last_q && (cnt_q == take_n);
    end
  end

  // Control registers of the block state and search sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      last_q     <= 1'b0;
      fill_q     <= '0;
      head_q     <= '0;
      rd_addr_q  <= '0;
      iss_q      <= '0;
      wcnt_q     <= '0;
      elem_vld_q <= 1'b0;
      sel_hist_q <= 1'b0;
      best_len_q <= '0;
      best_off_q <= '0;
      cons_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      // accept a byte
      if (cmd_i.load_in) begin
        cnt_q  <= cnt_q + CW'(1);
        last_q <= in_data_i.block_end;
      end
      // start a sweep from the oldest stored byte
      if (cmd_i.search_start) begin
        iss_q      <= '0;
        wcnt_q     <= '0;
        elem_vld_q <= 1'b0;
        best_len_q <= '0;
        best_off_q <= '0;
        rd_addr_q  <= (fill_q == W_F) ? head_q : '0;
      end else begin
        elem_vld_q <= issue;
        if (issue) begin
          iss_q      <= iss_q + SW'(1);
          sel_hist_q <= iss_q < fill_s;
          rd_addr_q  <= (rd_addr_q == W_LAST) ? '0 : rd_addr_q + AW'(1);
        end
        if (elem_vld_q) begin
          wcnt_q <= wcnt_q + SW'(1);
        end
        // keep the longest; on equal length keep the farthest seen first
        if (cand && (cur_len > best_len_q)) begin
          best_len_q <= cur_len;
          best_off_q <= FW'(fill_s - cand_pos);
        end
      end
      // token handoff
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
        cons_q    <= take_n;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      // move one consumed byte into history
      if (cmd_i.consume_step) begin
        cnt_q  <= cnt_q - CW'(1);
        cons_q <= cons_q - CW'(1);
        head_q <= (head_q == W_LAST) ? '0 : head_q + AW'(1);
        if (fill_q != W_F) fill_q <= fill_q + FW'(1);
      end
      // drop history at block end
      if (cmd_i.clear_blk) begin
        cnt_q  <= '0;
        last_q <= 1'b0;
        fill_q <= '0;
        head_q <= '0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/lz77_greedy_compressor.sv
// Channel | Handshake              | Payload
// input   | in_valid_i/in_ready_o   | in_data_i  (lzc_in_t: in_byte, block_end)
// output  | out_valid_o/out_ready_i | out_data_o (lzc_out_t: kind, offset, length, byte, last)
//
// A byte that fills no token passes only through the idle and check states. A token's search
// sweeps the stored history and the lookahead, one candidate start per cycle (set by the single history read port
// feeding a MAX_MATCH-byte window), and each consumed byte then moves into history.
// Reset clears all control state; history content needs no clearing.
// A stalled output holds the next token in the search result until the register frees.
// Top level: controller plus datapath. Depends on lzc_pkg, lzc_ctrl, lzc_dp.
module lz77_greedy_compressor
  import lzc_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 1024,
  parameter int unsigned MAX_MATCH   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lzc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lzc_out_t out_data_o
);

  lzc_cmd_t cmd;
  lzc_sts_t sts;

  lzc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lzc_dp #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_MATCH   (MAX_MATCH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/lzc_chk.sv
// Port-level checker for the LZ77 compressor, bound to the top level.
// Depends on lzc_pkg.
module lzc_chk
  import lzc_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 1024,
  parameter int unsigned MAX_MATCH   = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input lzc_in_t  in_data_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input lzc_out_t out_data_i
);

  // Pending token holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output transaction dropped or changed while stalled");

  // Token fields are consistent with their kind
  a_token_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.kind == KIND_MATCH)
      ? (out_data_i.match_length >= LEN_W'(2) && out_data_i.match_length <= LEN_W'(MAX_MATCH)
         && out_data_i.match_offset != '0
         && 32'(out_data_i.match_offset) <= WINDOW_SIZE)
      : (out_data_i.match_length == '0 && out_data_i.match_offset == '0))
    else $error("malformed token");

  // Each accepted byte is examined before another is taken
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  // A new token appears only while input is held off
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("token produced while idle");

endmodule

bind lz77_greedy_compressor lzc_chk #(
  .WINDOW_SIZE (WINDOW_SIZE),
  .MAX_MATCH   (MAX_MATCH)
) u_lzc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
